// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies a consequence in the same cycle.
`define PFA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition implies a consequence in the following cycle.
`define PFA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/pfa_pkg.sv
// Package with constants, types and helper functions of the page frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;
   localparam int NUM_PAGES   = 1024;
   localparam int CACHE_DEPTH = 64;
   localparam int PAGE_W      = 10;
   localparam int CNT_W       = 11;
   localparam int WORD_W      = 32;
   localparam int WORD_AW     = $clog2(WORD_W);
   localparam int MAP_WORDS   = NUM_PAGES / WORD_W;
   localparam int MAP_AW      = $clog2(MAP_WORDS);
   localparam int CACHE_AW    = $clog2(CACHE_DEPTH);
   localparam int FILL_W      = 7;
   localparam int CSR_IDX_W   = 1;

   typedef enum logic [1:0] {
      CMD_FREE  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_RUN   = 2'd2,
      CMD_INIT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NULL     = 2'd1,
      ST_BAD_FREE = 2'd2,
      ST_NO_RUN   = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_PAGE = 1'b0,
      CSR_TOP_PAGE = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FREE_RD,
      S_FREE_WR,
      S_POP,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_RUN_RD,
      S_RUN_CHK,
      S_CLR_RD,
      S_CLR_WR,
      S_INIT,
      S_RESP
   } state_type;

   // Bits of bitmap word w whose page index lies in [lo, hi).
   function automatic logic [WORD_W-1:0] range_mask(input logic [MAP_AW-1:0] w,
                                                    input logic [CNT_W-1:0] lo,
                                                    input logic [CNT_W-1:0] hi);
      logic [WORD_W-1:0] m;
      int p;
      m = '0;
      for (int k = 0; k < WORD_W; k++) begin
         p = int'(w) * WORD_W + k;
         m[k] = (p >= int'(lo)) && (p < int'(hi));
      end
      return m;
   endfunction

   // Bit j is set when a run of n free pages ends at bit j of this word,
   // given c free pages directly below the word.
   function automatic logic [WORD_W-1:0] run_hit(input logic [WORD_W-1:0] d,
                                                 input logic [CNT_W-1:0] c,
                                                 input logic [CNT_W-1:0] n);
      logic [WORD_W-1:0] h;
      logic ok;
      h = '0;
      for (int j = 0; j < WORD_W; j++) begin
         ok = 1'b1;
         for (int k = 0; k < WORD_W; k++) begin
            if ((k <= j) && (k + int'(n) > j) && !d[k]) begin
               ok = 1'b0;
            end
         end
         h[j] = ok && ((int'(n) <= j + 1) || (int'(c) + j + 1 >= int'(n)));
      end
      return h;
   endfunction

   function automatic logic [WORD_AW-1:0] lowest_one(input logic [WORD_W-1:0] v);
      logic [WORD_AW-1:0] idx;
      idx = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (v[j]) begin
            idx = WORD_AW'(j);
         end
      end
      return idx;
   endfunction

   // Number of set bits directly below the top of a word that is not all ones.
   function automatic logic [CNT_W-1:0] top_ones(input logic [WORD_W-1:0] d);
      logic [CNT_W-1:0] cnt;
      cnt = '0;
      for (int j = 0; j < WORD_W; j++) begin
         if (!d[j]) begin
            cnt = CNT_W'(WORD_W - 1 - j);
         end
      end
      return cnt;
   endfunction
endpackage
`default_nettype wire

// File: rtl/core/pfa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/page_frame_allocator_core.sv
// Top level of the page frame allocator with a LIFO cache and a free bitmap.
// Usage: a command transfer on the req_ channel (free, allocate one page,
// allocate a contiguous run, initialize) yields exactly one transfer on the
// rsp_ channel with the page, a status code and the cache fill after the step.
// The block works on one command at a time; req_ready is high only when idle.
// A free pushes the page onto the cache or, if it is full, sets the page's
// bitmap bit by a read-modify-write. An allocate pops the cache or, if it is
// empty, scans the bitmap one 32-page word at a time; a run allocation scans
// too and clears each word of the run; initialize refills cache and bitmap.
// The result sits in an output register, so a new request is taken while it
// waits; a stalled receiver holds the next result inside the block.
// The csr_ channel writes low_page and top_page and is always ready; write
// it only while the block is idle. Reset returns both registers to their
// defaults, empties the cache and marks the bitmap empty through per-word
// valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module page_frame_allocator_core import pfa_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_cmd,
   input  wire logic [PAGE_W-1:0]    req_page,
   input  wire logic [CNT_W-1:0]     req_count,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [PAGE_W-1:0]    rsp_page_out,
   output logic      [1:0]           rsp_status,
   output logic      [FILL_W-1:0]    rsp_cache_fill,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CNT_W-1:0]     csr_data
);
   state_type state_ff, state_in;
   logic [CNT_W-1:0] low_ff, low_in, top_ff, top_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [CNT_W-1:0] num_ff, num_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [MAP_AW-1:0] word_ff, word_in, stop_ff, stop_in;
   logic [CNT_W-1:0] carry_ff, carry_in, start_ff, start_in, end_ff, end_in;
   logic [CACHE_AW-1:0] icnt_ff, icnt_in;
   logic [CNT_W-1:0] ihi_ff, ihi_in, ibmhi_ff, ibmhi_in;
   logic [FILL_W-1:0] ifill_ff, ifill_in;
   logic [PAGE_W-1:0] res_page_ff, res_page_in;
   status_type res_status_ff, res_status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0] rsp_page_ff, rsp_page_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [FILL_W-1:0] rsp_fill_ff, rsp_fill_in;
   logic [MAP_WORDS-1:0] mvalid_ff, mvalid_in;
   logic rd_valid_ff, rd_valid_in;

   logic stack_we, stack_re;
   logic [CACHE_AW-1:0] stack_waddr, stack_raddr;
   logic [PAGE_W-1:0] stack_wdata, stack_rdata;
   logic map_we, map_re;
   logic [MAP_AW-1:0] map_waddr, map_raddr;
   logic [WORD_W-1:0] map_wdata, map_rdata, map_word, hits;
   logic [WORD_AW-1:0] bit_idx;
   logic [CNT_W-1:0] ipos, hi_w, span;
   logic page_ok;

   pfa_ram #(.WIDTH(PAGE_W), .DEPTH(CACHE_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_en   (stack_re),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   pfa_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_en   (map_re),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   assign req_ready      = (state_ff == S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_page_out   = rsp_page_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_cache_fill = rsp_fill_ff;

   assign map_word = map_rdata & {WORD_W{rd_valid_ff}};
   assign page_ok  = ({1'b0, req_page} >= low_ff) && ({1'b0, req_page} < top_ff);
   assign hi_w     = (top_ff > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : top_ff;
   assign span     = (hi_w > low_ff) ? (hi_w - low_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         low_ff       <= '0;
         top_ff       <= CNT_W'(NUM_PAGES);
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         mvalid_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         top_ff       <= top_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         mvalid_ff    <= mvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      num_ff        <= num_in;
      word_ff       <= word_in;
      stop_ff       <= stop_in;
      carry_ff      <= carry_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      icnt_ff       <= icnt_in;
      ihi_ff        <= ihi_in;
      ibmhi_ff      <= ibmhi_in;
      ifill_ff      <= ifill_in;
      res_page_ff   <= res_page_in;
      res_status_ff <= res_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff   <= rsp_fill_in;
      rd_valid_ff   <= rd_valid_in;
   end

   always_comb begin
      low_in = low_ff;
      top_in = top_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_LOW_PAGE: low_in = csr_data;
            CSR_TOP_PAGE: top_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      mvalid_in = mvalid_ff;
      if (map_we) begin
         mvalid_in[map_waddr] = 1'b1;
      end
      rd_valid_in = map_re ? mvalid_ff[map_raddr] : rd_valid_ff;
   end

   always_comb begin
      state_in      = state_ff;
      page_in       = page_ff;
      num_in        = num_ff;
      fill_in       = fill_ff;
      word_in       = word_ff;
      stop_in       = stop_ff;
      carry_in      = carry_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      icnt_in       = icnt_ff;
      ihi_in        = ihi_ff;
      ibmhi_in      = ibmhi_ff;
      ifill_in      = ifill_ff;
      res_page_in   = res_page_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in   = rsp_fill_ff;
      stack_we      = 1'b0;
      stack_waddr   = fill_ff[CACHE_AW-1:0];
      stack_wdata   = page_ff;
      stack_re      = 1'b0;
      stack_raddr   = fill_ff[CACHE_AW-1:0];
      map_we        = 1'b0;
      map_waddr     = word_ff;
      map_wdata     = '0;
      map_re        = 1'b0;
      map_raddr     = word_ff;
      hits          = run_hit(map_word, carry_ff, num_ff);
      bit_idx       = lowest_one((state_ff == S_RUN_CHK) ? hits : map_word);
      ipos          = {1'b0, word_ff, bit_idx};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               page_in       = req_page;
               num_in        = req_count;
               res_page_in   = '0;
               res_status_in = ST_OK;
               case (cmd_type'(req_cmd))
                  CMD_FREE: begin
                     if (!page_ok) begin
                        res_status_in = ST_BAD_FREE;
                        state_in      = S_RESP;
                     end else if (fill_ff < FILL_W'(CACHE_DEPTH)) begin
                        stack_we    = 1'b1;
                        stack_wdata = req_page;
                        fill_in     = fill_ff + 1'b1;
                        state_in    = S_RESP;
                     end else begin
                        state_in = S_FREE_RD;
                     end
                  end
                  CMD_ALLOC: begin
                     if (fill_ff != '0) begin
                        stack_re    = 1'b1;
                        stack_raddr = CACHE_AW'(fill_ff - 1'b1);
                        fill_in     = fill_ff - 1'b1;
                        state_in    = S_POP;
                     end else begin
                        word_in  = '0;
                        state_in = S_SCAN_RD;
                     end
                  end
                  CMD_RUN: begin
                     if (req_count == '0) begin
                        res_status_in = ST_NULL;
                        state_in      = S_RESP;
                     end else begin
                        word_in  = '0;
                        carry_in = '0;
                        state_in = S_RUN_RD;
                     end
                  end
                  CMD_INIT: begin
                     ihi_in   = hi_w;
                     ifill_in = (span >= CNT_W'(CACHE_DEPTH)) ? FILL_W'(CACHE_DEPTH)
                                                               : FILL_W'(span);
                     ibmhi_in = (span > CNT_W'(CACHE_DEPTH)) ? (hi_w - CNT_W'(CACHE_DEPTH))
                                                              : low_ff;
                     icnt_in  = '0;
                     state_in = S_INIT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FREE_RD: begin
            map_re    = 1'b1;
            map_raddr = page_ff[PAGE_W-1:WORD_AW];
            state_in  = S_FREE_WR;
         end
         S_FREE_WR: begin
            map_we    = 1'b1;
            map_waddr = page_ff[PAGE_W-1:WORD_AW];
            map_wdata = map_word | (WORD_W'(1) << page_ff[WORD_AW-1:0]);
            state_in  = S_RESP;
         end
         S_POP: begin
            res_page_in = stack_rdata;
            state_in    = S_RESP;
         end
         S_SCAN_RD, S_RUN_RD: begin
            map_re   = 1'b1;
            state_in = (state_ff == S_SCAN_RD) ? S_SCAN_CHK : S_RUN_CHK;
         end
         S_SCAN_CHK: begin
            if (map_word != '0) begin
               map_we      = 1'b1;
               map_wdata   = map_word & ~(WORD_W'(1) << bit_idx);
               res_page_in = {word_ff, bit_idx};
               state_in    = S_RESP;
            end else if (word_ff == MAP_AW'(MAP_WORDS - 1)) begin
               res_status_in = ST_NULL;
               state_in      = S_RESP;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_RUN_CHK: begin
            if (hits != '0) begin
               start_in    = ipos + 1'b1 - num_ff;
               end_in      = ipos + 1'b1;
               stop_in     = word_ff;
               word_in     = start_in[PAGE_W-1:WORD_AW];
               res_page_in = start_in[PAGE_W-1:0];
               state_in    = S_CLR_RD;
            end else begin
               carry_in = (&map_word) ? (carry_ff + CNT_W'(WORD_W)) : top_ones(map_word);
               if (word_ff == MAP_AW'(MAP_WORDS - 1)) begin
                  res_status_in = ST_NO_RUN;
                  state_in      = S_RESP;
               end else begin
                  word_in  = word_ff + 1'b1;
                  state_in = S_RUN_RD;
               end
            end
         end
         S_CLR_RD: begin
            map_re   = 1'b1;
            state_in = S_CLR_WR;
         end
         S_CLR_WR: begin
            map_we    = 1'b1;
            map_wdata = map_word & ~range_mask(word_ff, start_ff, end_ff);
            if (word_ff == stop_ff) begin
               state_in = S_RESP;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = S_CLR_RD;
            end
         end
         S_INIT: begin
            stack_we    = 1'b1;
            stack_waddr = icnt_ff;
            stack_wdata = PAGE_W'(ihi_ff - 1'b1 - CNT_W'(icnt_ff));
            if (int'(icnt_ff) < MAP_WORDS) begin
               map_we    = 1'b1;
               map_waddr = MAP_AW'(icnt_ff);
               map_wdata = range_mask(MAP_AW'(icnt_ff), low_ff, ibmhi_ff);
            end
            if (icnt_ff == CACHE_AW'(CACHE_DEPTH - 1)) begin
               fill_in  = ifill_ff;
               state_in = S_RESP;
            end else begin
               icnt_in = icnt_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_page_in   = res_page_ff;
               rsp_status_in = res_status_ff;
               rsp_fill_in   = fill_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/core/pfa_checker.sv
// Port-level assertion checker for the page frame allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pfa_checker import pfa_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [PAGE_W-1:0]    rsp_page_out,
   input wire logic [1:0]           rsp_status,
   input wire logic [FILL_W-1:0]    rsp_cache_fill
);
   `PFA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_page_out) && $stable(rsp_status), "Result changed while stalled.")
   `PFA_ASSERT_IMP(a_err_zero, rsp_valid && (rsp_status != ST_OK),
      rsp_page_out == '0, "Error result carries a nonzero page.")
   `PFA_ASSERT_IMP(a_fill_max, rsp_valid,
      rsp_cache_fill <= FILL_W'(CACHE_DEPTH), "Cache fill exceeds the cache depth.")
   `PFA_ASSERT_NXT(a_one_item, req_valid && req_ready,
      !req_ready, "Request taken while a command is still in progress.")
endmodule

bind page_frame_allocator_core pfa_checker u_pfa_checker (.*);
`default_nettype wire

// File: tb/sv/page_frame_allocator_core_tb.sv
// Self-checking testbench for the page frame allocator core.
`timescale 1ns / 1ps
`default_nettype none
module page_frame_allocator_core_tb import pfa_pkg::*; ();
   typedef struct packed {
      logic [PAGE_W-1:0] page_out;
      status_type        status;
      logic [FILL_W-1:0] fill;
   } alloc_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_cmd;
   logic [PAGE_W-1:0]    req_page;
   logic [CNT_W-1:0]     req_count;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [PAGE_W-1:0]    rsp_page_out;
   logic [1:0]           rsp_status;
   logic [FILL_W-1:0]    rsp_cache_fill;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CNT_W-1:0]     csr_data;

   page_frame_allocator_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_page(req_page), .req_count(req_count),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_page_out(rsp_page_out),
      .rsp_status(rsp_status), .rsp_cache_fill(rsp_cache_fill),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Predictor state.
   logic [CNT_W-1:0]   low_reg;
   logic [CNT_W-1:0]   top_reg;
   logic [PAGE_W-1:0]  lifo [CACHE_DEPTH];
   int                 lifo_depth;
   bit [NUM_PAGES-1:0] bitmap;

   alloc_result_type expected_q[$];
   int  send_idle_pct;
   int  recv_idle_pct;
   int  error_count = 0;
   int  result_count = 0;
   int  cmd_seen [4];
   longint cycle_count = 0;

   initial begin
      clock = 1'b0;
   end
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("Timeout at %0t", $time);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic void put_page(input int p);
      if (lifo_depth < CACHE_DEPTH) begin
         lifo[lifo_depth] = p[PAGE_W-1:0];
         lifo_depth++;
      end else begin
         bitmap[p] = 1'b1;
      end
   endfunction

   function automatic alloc_result_type allocator_predict(input cmd_type cmd,
                                                         input logic [PAGE_W-1:0] page,
                                                         input logic [CNT_W-1:0] count);
      alloc_result_type r;
      int run;
      int hi;
      r.page_out = '0;
      r.status = ST_OK;
      case (cmd)
         CMD_FREE: begin
            if (page < low_reg || page >= top_reg) r.status = ST_BAD_FREE;
            else put_page(page);
         end
         CMD_ALLOC: begin
            if (lifo_depth > 0) begin
               lifo_depth--;
               r.page_out = lifo[lifo_depth];
            end else begin
               r.status = ST_NULL;
               for (int i = 0; i < NUM_PAGES; i++) begin
                  if (bitmap[i]) begin
                     bitmap[i] = 1'b0;
                     r.page_out = i[PAGE_W-1:0];
                     r.status = ST_OK;
                     break;
                  end
               end
            end
         end
         CMD_RUN: begin
            if (count == 0) r.status = ST_NULL;
            else begin
               r.status = ST_NO_RUN;
               run = 0;
               for (int i = 0; i < NUM_PAGES; i++) begin
                  run = bitmap[i] ? run + 1 : 0;
                  if (run == int'(count)) begin
                     for (int k = i + 1 - run; k <= i; k++) bitmap[k] = 1'b0;
                     r.page_out = PAGE_W'(i + 1 - run);
                     r.status = ST_OK;
                     break;
                  end
               end
            end
         end
         default: begin
            hi = (top_reg > NUM_PAGES) ? NUM_PAGES : int'(top_reg);
            lifo_depth = 0;
            bitmap = '0;
            for (int p = hi; p > int'(low_reg); p--) put_page(p - 1);
         end
      endcase
      r.fill = FILL_W'(lifo_depth);
      return r;
   endfunction

   task automatic send_command(input cmd_type cmd, input int page, input int count);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_page  <= page[PAGE_W-1:0];
      req_count <= count[CNT_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_q.push_back(allocator_predict(cmd, page[PAGE_W-1:0], count[CNT_W-1:0]));
      cmd_seen[cmd]++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_q.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input int value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CNT_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_LOW_PAGE) low_reg = value[CNT_W-1:0];
      else top_reg = value[CNT_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (!reset) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result page %0d status %0d fill %0d", $time,
                     rsp_page_out, rsp_status, rsp_cache_fill);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_page_out !== want.page_out) begin
               $display("%0t: page_out expected %0d actual %0d", $time,
                        want.page_out, rsp_page_out);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_status);
               error_count++;
            end
            if (rsp_cache_fill !== want.fill) begin
               $display("%0t: cache_fill expected %0d actual %0d", $time,
                        want.fill, rsp_cache_fill);
               error_count++;
            end
         end
      end
   end

   task automatic test_empty_allocator();
      send_command(CMD_ALLOC, 0, 0);
      send_command(CMD_RUN, 0, 1);
      send_command(CMD_RUN, 0, 0);
      send_command(CMD_FREE, 1023, 0);
      send_command(CMD_FREE, 5, 0);
      send_command(CMD_FREE, 0, 0);
      send_command(CMD_ALLOC, 0, 0);
      send_command(CMD_ALLOC, 0, 0);
   endtask

   task automatic test_full_init();
      send_command(CMD_INIT, 0, 0);
      send_command(CMD_ALLOC, 0, 0);
      send_command(CMD_RUN, 0, 1024);
      send_command(CMD_RUN, 0, 2047);
      send_command(CMD_RUN, 0, 960);
      send_command(CMD_RUN, 0, 1);
      send_command(CMD_FREE, 3, 0);
      send_command(CMD_FREE, 3, 0);
      send_command(CMD_INIT, 0, 0);
      send_command(CMD_RUN, 0, 900);
      send_command(CMD_RUN, 0, 60);
      repeat (66) send_command(CMD_ALLOC, 0, 0);
   endtask

   task automatic test_register_limits();
      write_register(CSR_LOW_PAGE, 1024);
      write_register(CSR_TOP_PAGE, 0);
      send_command(CMD_INIT, 0, 0);
      send_command(CMD_FREE, 0, 0);
      write_register(CSR_LOW_PAGE, 1000);
      write_register(CSR_TOP_PAGE, 2047);
      send_command(CMD_INIT, 0, 0);
      send_command(CMD_FREE, 999, 0);
      send_command(CMD_FREE, 1023, 0);
      write_register(CSR_LOW_PAGE, 10);
      write_register(CSR_TOP_PAGE, 20);
      send_command(CMD_FREE, 20, 0);
      send_command(CMD_FREE, 9, 0);
      send_command(CMD_INIT, 0, 0);
   endtask

   task automatic test_random_traffic(input int items, input int low, input int top);
      int sel;
      write_register(CSR_LOW_PAGE, low);
      write_register(CSR_TOP_PAGE, top);
      send_command(CMD_INIT, 0, 0);
      for (int n = 0; n < items; n++) begin
         sel = $urandom_range(99);
         if (sel < 35) send_command(CMD_FREE, $urandom_range(1023), 0);
         else if (sel < 65) send_command(CMD_ALLOC, $urandom_range(1023), 0);
         else if (sel < 97) send_command(CMD_RUN, $urandom_range(1023),
                                         ($urandom_range(9) == 0) ?
                                         $urandom_range(2047) : $urandom_range(12));
         else send_command(CMD_INIT, $urandom_range(1023), $urandom_range(2047));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_FREE;
      req_page = '0;
      req_count = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_LOW_PAGE;
      csr_data = '0;
      low_reg = 0;
      top_reg = 1024;
      lifo_depth = 0;
      bitmap = '0;
      send_idle_pct = 24;
      recv_idle_pct = 67;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_allocator();
      test_full_init();
      test_register_limits();
      test_random_traffic(100, 0, 1024);
      send_idle_pct = 67;
      recv_idle_pct = 24;
      test_random_traffic(100, 1, 100);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(110, $urandom_range(200), 300 + $urandom_range(1747));
      wait_drained();

      $display("Covered %0d results: free %0d, alloc %0d, run %0d, init %0d commands.",
               result_count, cmd_seen[CMD_FREE], cmd_seen[CMD_ALLOC],
               cmd_seen[CMD_RUN], cmd_seen[CMD_INIT]);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/pfa_pkg.sv
rtl/core/pfa_ram.sv
rtl/core/page_frame_allocator_core.sv
rtl/core/pfa_checker.sv
tb/sv/page_frame_allocator_core_tb.sv
